FILE: hdl/cqr_pkg.sv
package cqr_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned FracWidth = 16;

  // internal widths
  localparam int unsigned ProdW    = 2 * WordWidth;
  localparam int unsigned RndW     = ProdW + 2 - FracWidth;
  localparam int unsigned DiscW    = RndW + 3;
  localparam int unsigned MagW     = DiscW;
  localparam int unsigned HalfW    = (MagW + 1) / 2;
  localparam int unsigned Sqrt1N   = MagW + 1;
  localparam int unsigned SqW      = 2 * Sqrt1N;
  localparam int unsigned Sqrt2N   = (Sqrt1N + FracWidth + 1) / 2;
  localparam int unsigned NumInW   = Sqrt2N + 2;
  localparam int unsigned NumProdW = NumInW + WordWidth + 1;
  localparam int unsigned NumW     = NumProdW + 1;
  localparam int unsigned DenW     = ProdW + 3;
  localparam int unsigned RemW     = DenW + WordWidth;

  localparam logic [ProdW:0] RndHalf = (ProdW + 1)'(1) << (FracWidth - 1);

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StAZero = 2'd1,
    StSat   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [WordWidth-1:0] a_re;
    logic signed [WordWidth-1:0] a_im;
    logic signed [WordWidth-1:0] b_re;
    logic signed [WordWidth-1:0] b_im;
    logic signed [WordWidth-1:0] c_re;
    logic signed [WordWidth-1:0] c_im;
  } coef_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] root1_re;
    logic signed [WordWidth-1:0] root1_im;
    logic signed [WordWidth-1:0] root2_re;
    logic signed [WordWidth-1:0] root2_im;
    logic        [1:0]           status;
  } result_t;

  // product sum back to FracWidth fraction bits, half away from zero
  function automatic logic signed [RndW-1:0] rnd(input logic signed [ProdW:0] x);
    logic [ProdW:0]         mag;
    logic [ProdW:0]         m;
    logic signed [RndW-1:0] r;
    mag = x[ProdW] ? (~x + 1'b1) : x;
    m   = (mag + RndHalf) >> FracWidth;
    r   = $signed(m[RndW-1:0]);
    if (x[ProdW]) begin
      r = -r;
    end
    return r;
  endfunction

endpackage

FILE: hdl/cqr_sqrt_cell.sv
module cqr_sqrt_cell
  import cqr_pkg::*;
#(
  parameter int unsigned N     = 8,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             v_i,
  input  logic [2*N-1:0]   x_i,
  input  logic [N:0]       rem_i,
  input  logic [N-1:0]     root_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output logic [2*N-1:0]   x_o,
  output logic [N:0]       rem_o,
  output logic [N-1:0]     root_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [N+2:0] cur;
  logic [N+2:0] trial;
  logic [N+2:0] diff;
  logic         ge;

  assign cur   = {rem_i, x_i[2*N-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign diff  = cur - trial;
  assign ge    = (cur >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_o    <= x_i << 2;
    rem_o  <= ge ? diff[N:0] : cur[N:0];
    root_o <= {root_i[N-2:0], ge};
    tag_o  <= tag_i;
  end

endmodule

FILE: hdl/cqr_sqrt.sv
module cqr_sqrt
  import cqr_pkg::*;
#(
  parameter int unsigned N     = 8,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             v_i,
  input  logic [2*N-1:0]   x_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output logic [N-1:0]     root_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [N:0]                  v_w;
  logic [N:0][2*N-1:0]         x_w;
  logic [N:0][N:0]             rem_w;
  logic [N:0][N-1:0]           root_w;
  logic [N:0][TAG_W-1:0]       tag_w;

  assign v_w[0]    = v_i;
  assign x_w[0]    = x_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign tag_w[0]  = tag_i;

  for (genvar g = 0; g < N; g++) begin : g_cell
    cqr_sqrt_cell #(
      .N     (N),
      .TAG_W (TAG_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (v_w[g]),
      .x_i    (x_w[g]),
      .rem_i  (rem_w[g]),
      .root_i (root_w[g]),
      .tag_i  (tag_w[g]),
      .v_o    (v_w[g+1]),
      .x_o    (x_w[g+1]),
      .rem_o  (rem_w[g+1]),
      .root_o (root_w[g+1]),
      .tag_o  (tag_w[g+1])
    );
  end

  assign v_o    = v_w[N];
  assign root_o = root_w[N];
  assign tag_o  = tag_w[N];

endmodule

FILE: hdl/cqr_div_cell.sv
module cqr_div_cell
  import cqr_pkg::*;
#(
  parameter int unsigned CW    = 64,
  parameter int unsigned DENW  = 32,
  parameter int unsigned QW    = 16,
  parameter int unsigned K     = 0,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             v_i,
  input  logic [DENW-1:0]  den_i,
  input  logic [CW-1:0]    rem_i,
  input  logic [QW-1:0]    q_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output logic [DENW-1:0]  den_o,
  output logic [CW-1:0]    rem_o,
  output logic [QW-1:0]    q_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [CW-1:0] shifted;
  logic          ge;

  assign shifted = CW'(den_i) << K;
  assign ge      = (rem_i >= shifted);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_o <= den_i;
    rem_o <= ge ? (rem_i - shifted) : rem_i;
    q_o   <= {q_i[QW-2:0], ge};
    tag_o <= tag_i;
  end

endmodule

FILE: hdl/cqr_div.sv
module cqr_div
  import cqr_pkg::*;
#(
  parameter int unsigned CW    = 64,
  parameter int unsigned DENW  = 32,
  parameter int unsigned QW    = 16,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             v_i,
  input  logic [DENW-1:0]  den_i,
  input  logic [CW-1:0]    dvd_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output logic [QW-1:0]    q_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [QW:0]                v_w;
  logic [QW:0][DENW-1:0]      den_w;
  logic [QW:0][CW-1:0]        rem_w;
  logic [QW:0][QW-1:0]        q_w;
  logic [QW:0][TAG_W-1:0]     tag_w;

  assign v_w[0]   = v_i;
  assign den_w[0] = den_i;
  assign rem_w[0] = dvd_i;
  assign q_w[0]   = '0;
  assign tag_w[0] = tag_i;

  for (genvar g = 0; g < QW; g++) begin : g_cell
    cqr_div_cell #(
      .CW    (CW),
      .DENW  (DENW),
      .QW    (QW),
      .K     (QW - 1 - g),
      .TAG_W (TAG_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (v_w[g]),
      .den_i  (den_w[g]),
      .rem_i  (rem_w[g]),
      .q_i    (q_w[g]),
      .tag_i  (tag_w[g]),
      .v_o    (v_w[g+1]),
      .den_o  (den_w[g+1]),
      .rem_o  (rem_w[g+1]),
      .q_o    (q_w[g+1]),
      .tag_o  (tag_w[g+1])
    );
  end

  assign v_o   = v_w[QW];
  assign q_o   = q_w[QW];
  assign tag_o = tag_w[QW];

endmodule

FILE: hdl/complex_quadratic_roots.sv
// Complex quadratic root solver, signed Q16.16 in and out.
// Input channel: a coefficient word (a, b, c complex) on coef_i is taken at
// every rising edge with start high and busy low. busy is always low, so a
// new word may be given in every cycle.
// Output channel: valid_o is high for one cycle with both roots and the
// status on result_o; the receiver must take it then, it cannot stall.
// A word passes the three rows of square-root cells (54 and 35 cells deep),
// the rows of divider cells (32 deep) and 16 arithmetic stages.
// Throughput: one word per cycle, words leave in order.
// Status: 0 ok, 1 when a is zero (roots read zero), 2 when a root part
// was clamped to the Q16.16 range.
// Reset clears all valid flags; words in flight are dropped, no state is
// kept between words.
module complex_quadratic_roots
  import cqr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  coef_t   coef_i,
  output logic    valid_o,
  output result_t result_o
);

  localparam int unsigned W1 = WordWidth + 1;
  localparam int unsigned UW = Sqrt1N + 2;
  localparam int unsigned XW = 2 * Sqrt2N;
  localparam logic [WordWidth-1:0] MaxV = {1'b0, {(WordWidth-1){1'b1}}};
  localparam logic [WordWidth-1:0] MinV = {1'b1, {(WordWidth-1){1'b0}}};

  typedef struct packed {
    logic                 azero;
    logic signed [W1-1:0] nbr;
    logic signed [W1-1:0] nbi;
    logic signed [W1-1:0] dre;
    logic signed [W1-1:0] dim;
  } side_t;

  typedef struct packed {
    logic signed [DiscW-1:0] dr;
    logic                    di_neg;
    logic [DenW-1:0]         den;
    side_t                   side;
  } tag1_t;

  typedef struct packed {
    logic [DenW-1:0] den;
    side_t           side;
  } tag2_t;

  // front stages
  logic [8:0]                  vld_q;
  coef_t                       in_q;
  logic signed [ProdW-1:0]     p2_q [9];
  side_t                       side2_q, side3_q, side4_q, side5_q;
  logic signed [ProdW:0]       s3_q [4];
  logic [DenW-1:0]             den3_q, den4_q, den5_q;
  logic signed [RndW-1:0]      r4_q [4];
  logic signed [DiscW-1:0]     dr5_q, di5_q;
  logic [MagW-1:0]             m6_q [2];
  tag1_t                       t6_q, t7_q, t8_q, t9_q;
  logic [2*HalfW-1:0]          pp7_q [2][3];
  logic [SqW-1:0]              sq8_q [2];
  logic [SqW-1:0]              sum9_q;
  logic [HalfW-1:0]            hi7 [2];

  // first square root row
  logic                        r1_v;
  logic [Sqrt1N-1:0]           r1_root;
  tag1_t                       r1_tag;

  logic                        v10_q;
  logic [XW-1:0]               x10_q [2];
  logic                        dineg10_q;
  tag2_t                       t10_q;
  logic signed [UW-1:0]        u_sum, u_dif;

  // second square root rows
  logic                        r2a_v, r2b_v;
  logic [Sqrt2N-1:0]           r2a_root, r2b_root;
  tag2_t                       r2a_tag;
  logic                        r2b_tag;
  logic signed [NumInW-1:0]    sr, si;

  // back stages
  logic [4:0]                  post_q;
  logic signed [NumInW-1:0]    n11_q [4];
  logic signed [W1-1:0]        dre11_q, dim11_q;
  logic [DenW-1:0]             den11_q, den12_q, den13_q, den14_q, den15_q;
  logic                        az11_q, az12_q, az13_q, az14_q, az15_q;
  logic signed [NumProdW-1:0]  p12_q [8];
  logic signed [NumW-1:0]      num13_q [4];
  logic [NumW-1:0]             mag14_q [4];
  logic [3:0]                  neg14_q, neg15_q, ovf15_q;
  logic [RemW-1:0]             dvd15_q [4];
  logic [RemW-1:0]             dvd [4];
  logic [WordWidth-1:0]        az_q;

  // divider rows and output
  logic [3:0]                  dv_w;
  logic [WordWidth-1:0]        q_w [4];
  logic [1:0]                  dtag_w [4];
  logic [WordWidth-1:0]        val [4];
  logic [3:0]                  lsat;
  result_t                     res_d, res_q;
  logic                        valid_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      v10_q   <= 1'b0;
      post_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      vld_q   <= {vld_q[7:0], start};
      v10_q   <= r1_v;
      post_q  <= {post_q[3:0], r2a_v & r2b_v};
      valid_q <= &dv_w;
    end
  end

  // coefficient products, discriminant terms
  always_ff @(posedge clk_i) begin
    in_q <= coef_i;

    p2_q[0] <= in_q.b_re * in_q.b_re;
    p2_q[1] <= in_q.b_im * in_q.b_im;
    p2_q[2] <= in_q.b_re * in_q.b_im;
    p2_q[3] <= in_q.a_re * in_q.c_re;
    p2_q[4] <= in_q.a_im * in_q.c_im;
    p2_q[5] <= in_q.a_re * in_q.c_im;
    p2_q[6] <= in_q.a_im * in_q.c_re;
    p2_q[7] <= in_q.a_re * in_q.a_re;
    p2_q[8] <= in_q.a_im * in_q.a_im;
    side2_q.azero <= (in_q.a_re == '0) && (in_q.a_im == '0);
    side2_q.nbr   <= -W1'(in_q.b_re);
    side2_q.nbi   <= -W1'(in_q.b_im);
    side2_q.dre   <= W1'(in_q.a_re) <<< 1;
    side2_q.dim   <= W1'(in_q.a_im) <<< 1;

    s3_q[0] <= (ProdW + 1)'(p2_q[0]) - (ProdW + 1)'(p2_q[1]);
    s3_q[1] <= (ProdW + 1)'(p2_q[2]);
    s3_q[2] <= (ProdW + 1)'(p2_q[3]) - (ProdW + 1)'(p2_q[4]);
    s3_q[3] <= (ProdW + 1)'(p2_q[5]) + (ProdW + 1)'(p2_q[6]);
    den3_q  <= (DenW'($unsigned(p2_q[7])) + DenW'($unsigned(p2_q[8]))) << 2;
    side3_q <= side2_q;

    for (int i = 0; i < 4; i++) begin
      r4_q[i] <= rnd(s3_q[i]);
    end
    den4_q  <= den3_q;
    side4_q <= side3_q;

    dr5_q   <= DiscW'(r4_q[0]) - (DiscW'(r4_q[2]) <<< 2);
    di5_q   <= (DiscW'(r4_q[1]) <<< 1) - (DiscW'(r4_q[3]) <<< 2);
    den5_q  <= den4_q;
    side5_q <= side4_q;

    m6_q[0]     <= dr5_q[DiscW-1] ? $unsigned(-dr5_q) : $unsigned(dr5_q);
    m6_q[1]     <= di5_q[DiscW-1] ? $unsigned(-di5_q) : $unsigned(di5_q);
    t6_q.dr     <= dr5_q;
    t6_q.di_neg <= di5_q[DiscW-1];
    t6_q.den    <= den5_q;
    t6_q.side   <= side5_q;

    for (int l = 0; l < 2; l++) begin
      pp7_q[l][0] <= hi7[l] * hi7[l];
      pp7_q[l][1] <= hi7[l] * m6_q[l][HalfW-1:0];
      pp7_q[l][2] <= m6_q[l][HalfW-1:0] * m6_q[l][HalfW-1:0];
    end
    t7_q <= t6_q;

    for (int l = 0; l < 2; l++) begin
      sq8_q[l] <= (SqW'(pp7_q[l][0]) << (2 * HalfW)) + (SqW'(pp7_q[l][1]) << (HalfW + 1))
                  + SqW'(pp7_q[l][2]);
    end
    t8_q <= t7_q;

    sum9_q <= sq8_q[0] + sq8_q[1];
    t9_q   <= t8_q;
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hi7[l] = HalfW'(m6_q[l][MagW-1:HalfW]);
    end
  end

  cqr_sqrt #(
    .N     (Sqrt1N),
    .TAG_W ($bits(tag1_t))
  ) u_sqrt_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (vld_q[8]),
    .x_i    (sum9_q),
    .tag_i  (t9_q),
    .v_o    (r1_v),
    .root_o (r1_root),
    .tag_o  (r1_tag)
  );

  assign u_sum = $signed({2'b00, r1_root}) + UW'(r1_tag.dr);
  assign u_dif = $signed({2'b00, r1_root}) - UW'(r1_tag.dr);

  always_ff @(posedge clk_i) begin
    x10_q[0]   <= XW'({u_sum[Sqrt1N:1], {FracWidth{1'b0}}});
    x10_q[1]   <= XW'({u_dif[Sqrt1N:1], {FracWidth{1'b0}}});
    dineg10_q  <= r1_tag.di_neg;
    t10_q.den  <= r1_tag.den;
    t10_q.side <= r1_tag.side;
  end

  cqr_sqrt #(
    .N     (Sqrt2N),
    .TAG_W ($bits(tag2_t))
  ) u_sqrt_re (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (v10_q),
    .x_i    (x10_q[0]),
    .tag_i  (t10_q),
    .v_o    (r2a_v),
    .root_o (r2a_root),
    .tag_o  (r2a_tag)
  );

  cqr_sqrt #(
    .N     (Sqrt2N),
    .TAG_W (1)
  ) u_sqrt_im (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (v10_q),
    .x_i    (x10_q[1]),
    .tag_i  (dineg10_q),
    .v_o    (r2b_v),
    .root_o (r2b_root),
    .tag_o  (r2b_tag)
  );

  assign sr = $signed({2'b00, r2a_root});
  assign si = r2b_tag ? -$signed({2'b00, r2b_root}) : $signed({2'b00, r2b_root});

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      dvd[l] = RemW'(mag14_q[l]) << FracWidth;
    end
  end

  // numerators times conjugate of 2a, then sign and magnitude
  always_ff @(posedge clk_i) begin
    n11_q[0] <= NumInW'(r2a_tag.side.nbr) + sr;
    n11_q[1] <= NumInW'(r2a_tag.side.nbi) + si;
    n11_q[2] <= NumInW'(r2a_tag.side.nbr) - sr;
    n11_q[3] <= NumInW'(r2a_tag.side.nbi) - si;
    dre11_q  <= r2a_tag.side.dre;
    dim11_q  <= r2a_tag.side.dim;
    den11_q  <= r2a_tag.den;
    az11_q   <= r2a_tag.side.azero;

    for (int r = 0; r < 2; r++) begin
      p12_q[4*r]   <= n11_q[2*r]   * dre11_q;
      p12_q[4*r+1] <= n11_q[2*r+1] * dim11_q;
      p12_q[4*r+2] <= n11_q[2*r+1] * dre11_q;
      p12_q[4*r+3] <= n11_q[2*r]   * dim11_q;
    end
    den12_q <= den11_q;
    az12_q  <= az11_q;

    for (int r = 0; r < 2; r++) begin
      num13_q[2*r]   <= NumW'(p12_q[4*r])   + NumW'(p12_q[4*r+1]);
      num13_q[2*r+1] <= NumW'(p12_q[4*r+2]) - NumW'(p12_q[4*r+3]);
    end
    den13_q <= den12_q;
    az13_q  <= az12_q;

    for (int l = 0; l < 4; l++) begin
      mag14_q[l] <= num13_q[l][NumW-1] ? $unsigned(-num13_q[l]) : $unsigned(num13_q[l]);
      neg14_q[l] <= num13_q[l][NumW-1];
    end
    den14_q <= den13_q;
    az14_q  <= az13_q;

    for (int l = 0; l < 4; l++) begin
      dvd15_q[l] <= dvd[l];
      ovf15_q[l] <= (dvd[l] >= {den14_q, {WordWidth{1'b0}}});
    end
    neg15_q <= neg14_q;
    den15_q <= den14_q;
    az15_q  <= az14_q;

    az_q <= {az_q[WordWidth-2:0], az15_q};
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    cqr_div #(
      .CW    (RemW),
      .DENW  (DenW),
      .QW    (WordWidth),
      .TAG_W (2)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (post_q[4]),
      .den_i  (den15_q),
      .dvd_i  (dvd15_q[l]),
      .tag_i  ({ovf15_q[l], neg15_q[l]}),
      .v_o    (dv_w[l]),
      .q_o    (q_w[l]),
      .tag_o  (dtag_w[l])
    );
  end

  // clamp to the word range
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      val[l]  = q_w[l];
      lsat[l] = 1'b0;
      if (dtag_w[l][1]) begin
        val[l]  = dtag_w[l][0] ? MinV : MaxV;
        lsat[l] = 1'b1;
      end else if (!dtag_w[l][0]) begin
        if (q_w[l][WordWidth-1]) begin
          val[l]  = MaxV;
          lsat[l] = 1'b1;
        end
      end else begin
        if (q_w[l][WordWidth-1] && (|q_w[l][WordWidth-2:0])) begin
          val[l]  = MinV;
          lsat[l] = 1'b1;
        end else begin
          val[l] = -q_w[l];
        end
      end
    end
    if (az_q[WordWidth-1]) begin
      res_d.root1_re = '0;
      res_d.root1_im = '0;
      res_d.root2_re = '0;
      res_d.root2_im = '0;
      res_d.status   = StAZero;
    end else begin
      res_d.root1_re = val[0];
      res_d.root1_im = val[1];
      res_d.root2_re = val[2];
      res_d.root2_im = val[3];
      res_d.status   = (|lsat) ? StSat : StOk;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

FILE: dv/tb_top.sv
module tb_top;
  import cqr_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int unsigned LatencyCycles = 137;
  localparam int unsigned RandomWords   = 1150;
  localparam logic signed [31:0] One    = 32'sh0001_0000;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  logic    busy_n;
  coef_t   coef_i;
  logic    valid_o;
  result_t result_o;

  result_t roots_pending[$];
  int      n_errors;
  int      n_words;
  int      n_results;
  int      n_azero;
  int      n_sat;
  bit      no_gaps;

  complex_quadratic_roots u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .coef_i  (coef_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // busy only moves on a rising edge, so the falling-edge copy is the value at the next edge
  always @(negedge clk_i) begin
    busy_n <= busy;
  end

  function automatic wide_t widen(logic [31:0] v);
    return {{96{v[31]}}, v};
  endfunction

  // product sum back to 16 fraction bits, half away from zero
  function automatic wide_t round_frac(wide_t v);
    wide_t mg;
    mg = (v < 0) ? -v : v;
    mg = (mg + (wide_t'(1) <<< 15)) >>> 16;
    return (v < 0) ? -mg : mg;
  endfunction

  function automatic wide_t floor_sqrt(wide_t v);
    logic [127:0] x;
    logic [127:0] res;
    logic [127:0] b1;
    x   = v;
    res = '0;
    b1  = 128'd1 << 126;
    while (b1 > x) b1 = b1 >> 2;
    while (b1 != 0) begin
      if (x >= res + b1) begin
        x   = x - (res + b1);
        res = (res >> 1) + b1;
      end else begin
        res = res >> 1;
      end
      b1 = b1 >> 2;
    end
    return $signed(res);
  endfunction

  // scaled quotient, magnitude truncated
  function automatic wide_t frac_quot(wide_t n, wide_t d);
    wide_t mg;
    wide_t q;
    mg = ((n < 0) ? -n : n) <<< 16;
    q  = mg / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic [31:0] clamp_word(wide_t v, inout bit sat);
    if (v > wide_t'(32'sh7fff_ffff)) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -(wide_t'(1) <<< 31)) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic result_t solve_roots(coef_t c);
    wide_t   ar, ai, br, bi, cr, ci;
    wide_t   dr, di, t, m, sr, si, n1r, n1i, n2r, n2i, dre, dim, den;
    result_t r;
    bit      sat;
    ar  = widen(c.a_re);
    ai  = widen(c.a_im);
    br  = widen(c.b_re);
    bi  = widen(c.b_im);
    cr  = widen(c.c_re);
    ci  = widen(c.c_im);
    sat = 1'b0;
    r   = '0;
    if (ar == 0 && ai == 0) begin
      r.status = StAZero;
      return r;
    end
    dr = round_frac(br * br - bi * bi);
    t  = round_frac(br * bi);
    di = t + t;
    t  = round_frac(ar * cr - ai * ci);
    dr = dr - 4 * t;
    t  = round_frac(ar * ci + ai * cr);
    di = di - 4 * t;
    m  = floor_sqrt(dr * dr + di * di);
    sr = floor_sqrt(((m + dr) >>> 1) <<< 16);
    si = floor_sqrt(((m - dr) >>> 1) <<< 16);
    if (di < 0) si = -si;
    n1r = -br + sr;
    n1i = -bi + si;
    n2r = -br - sr;
    n2i = -bi - si;
    dre = ar + ar;
    dim = ai + ai;
    den = dre * dre + dim * dim;
    r.root1_re = clamp_word(frac_quot(n1r * dre + n1i * dim, den), sat);
    r.root1_im = clamp_word(frac_quot(n1i * dre - n1r * dim, den), sat);
    r.root2_re = clamp_word(frac_quot(n2r * dre + n2i * dim, den), sat);
    r.root2_im = clamp_word(frac_quot(n2i * dre - n2r * dim, den), sat);
    r.status   = sat ? StSat : StOk;
    return r;
  endfunction

  task automatic send_word(coef_t c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    coef_i <= c;
    start  <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy_n) break;
    end
    roots_pending.push_back(solve_roots(c));
    n_words++;
  endtask

  function automatic logic [31:0] rand_small();
    // up to about +-64.0 with a random fraction
    return $urandom_range(0, 1) ? -$urandom_range(0, 32'h40_0000)
                                : $urandom_range(0, 32'h40_0000);
  endfunction

  function automatic coef_t make_coef(logic [31:0] ar, logic [31:0] ai, logic [31:0] br,
                                      logic [31:0] bi, logic [31:0] cr, logic [31:0] ci);
    coef_t c;
    c.a_re = ar;
    c.a_im = ai;
    c.b_re = br;
    c.b_im = bi;
    c.c_re = cr;
    c.c_im = ci;
    return c;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (roots_pending.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, result_o);
        n_errors++;
      end else begin
        result_t exp_r;
        exp_r = roots_pending.pop_front();
        n_results++;
        if (exp_r.status == StAZero) n_azero++;
        if (exp_r.status == StSat) n_sat++;
        if (result_o.root1_re !== exp_r.root1_re || result_o.root1_im !== exp_r.root1_im) begin
          $display("%0t: root1 expected %h %h actual %h %h", $time, exp_r.root1_re,
                   exp_r.root1_im, result_o.root1_re, result_o.root1_im);
          n_errors++;
        end
        if (result_o.root2_re !== exp_r.root2_re || result_o.root2_im !== exp_r.root2_im) begin
          $display("%0t: root2 expected %h %h actual %h %h", $time, exp_r.root2_re,
                   exp_r.root2_im, result_o.root2_re, result_o.root2_im);
          n_errors++;
        end
        if (result_o.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   result_o.status);
          n_errors++;
        end
      end
    end
  end

  task automatic test_directed();
    no_gaps = 1'b0;
    // leading coefficient zero
    send_word(make_coef(0, 0, One, -One, 32'h1234_5678, 32'h8000_0000));
    send_word(make_coef(0, 0, 0, 0, 0, 0));
    // real roots, double root, purely imaginary roots
    send_word(make_coef(One, 0, 0, 0, -One, 0));
    send_word(make_coef(One, 0, -2 * One, 0, One, 0));
    send_word(make_coef(One, 0, 0, 0, One, 0));
    send_word(make_coef(One, 0, -3 * One, 0, 2 * One, 0));
    // imaginary leading coefficient and complex discriminant
    send_word(make_coef(0, One, One, One, -One, 2 * One));
    send_word(make_coef(-One, One, 0, -One, 0, One));
    // tiny a forces clamping
    send_word(make_coef(1, 0, One, 0, One, 0));
    send_word(make_coef(0, 32'hffff_ffff, 32'h7fff_ffff, 0, 0, 0));
    // field extremes
    send_word(make_coef(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff));
    send_word(make_coef(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000));
    send_word(make_coef(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                        32'h8000_0000, 32'h7fff_ffff));
    send_word(make_coef(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
                        32'hffff_ffff, 32'h0000_0001));
    // zero constant gives a root at zero
    send_word(make_coef(One, 0, One, 0, 0, 0));
    // real discriminant exactly zero with negative b
    send_word(make_coef(4 * One, 0, -4 * One, 0, One, 0));
  endtask

  task automatic test_random();
    coef_t c;
    int    kind;
    for (int i = 0; i < RandomWords; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        c = make_coef(rand_small(), rand_small(), rand_small(), rand_small(),
                      rand_small(), rand_small());
        if (c.a_re == 0 && c.a_im == 0) c.a_re = One;
      end else if (kind < 9) begin
        c = make_coef($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        c = make_coef(0, 0, $urandom, $urandom, $urandom, $urandom);
      end
      send_word(c);
    end
    start <= 1'b0;
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    while (roots_pending.size() != 0 && waited < 10 * LatencyCycles) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LatencyCycles + 20) @(posedge clk_i);
  endtask

  initial begin
    n_errors  = 0;
    n_words   = 0;
    n_results = 0;
    n_azero   = 0;
    n_sat     = 0;
    no_gaps   = 1'b0;
    start     = 1'b0;
    coef_i    = '0;
    rst_ni    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain_results();
    $display("sent %0d coefficient words, checked %0d results", n_words, n_results);
    $display("%0d with a zero, %0d saturated, %0d still pending", n_azero, n_sat,
             roots_pending.size());
    if (n_errors == 0 && roots_pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
hdl/cqr_pkg.sv
hdl/cqr_sqrt_cell.sv
hdl/cqr_sqrt.sv
hdl/cqr_div_cell.sv
hdl/cqr_div.sv
hdl/complex_quadratic_roots.sv
dv/tb_top.sv
